[rtl/sorted_key_table_defines.svh]
// assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// same-cycle implication
`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sktab_pkg.sv]
// shared types and codes of the sorted key table
package sktab_pkg;

	localparam int CAPACITY_DEF  = 256;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int IN_KEY_W      = 32;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int POS_W         = 9;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_W-1:0]    pos_out_t;

	localparam op_t OP_LOOKUP = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_DELETE = 2'd2;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_ABSENT = 2'd2;

	typedef struct packed {
		logic cmp_load;
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

endpackage

[rtl/sorted_key_table.sv]
// sorted key table: row of key cells with a stepped binary search
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------
//  in      | in_valid/in_stall  | op, key
//  out     | out_valid/out_stall| found, position, status, count
//  cfg     | cfg_we             | cfg_wdata (signed_keys)
//
// a transaction runs from acceptance to the next acceptance as a compare step
// that loads all cell compares, then the probes of the binary search until a
// hit or until the bounds meet, then an update step that shifts the cells and loads the result
// the result register frees the input side; the update waits while out_stall
// holds it full; arst_n clears the entry count, signed_keys and handshake state

`include "sorted_key_table_defines.svh"

module sorted_key_table #(
	parameter int CAPACITY  = sktab_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = sktab_pkg::KEY_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  sktab_pkg::op_t                    op,
	input  logic [sktab_pkg::IN_KEY_W-1:0]    key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output sktab_pkg::pos_out_t               position,
	output sktab_pkg::status_t                status,
	output sktab_pkg::pos_out_t               count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CMP    = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;
	localparam logic [1:0] S_UPDATE = 2'd3;

	logic [1:0]             state_q;
	logic                   signed_q;
	logic [CNT_W-1:0]       count_q;
	sktab_pkg::op_t         op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [KEY_WIDTH-1:0]   key_ord;
	logic [CNT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       hi1_q;
	logic                   found_q;
	logic [CNT_W-1:0]       pos_q;

	logic [KEY_WIDTH-1:0]   entry [CAPACITY];
	logic [CAPACITY-1:0]    lt_vec;
	logic [CAPACITY-1:0]    eq_vec;

	logic [CNT_W:0]         mid_sum;
	logic [CNT_W-1:0]       mid_w;
	logic [IDX_W-1:0]       mid_idx;

	logic                   in_accept;
	logic                   out_free;
	logic                   upd_go;
	logic                   is_ins;
	logic                   is_del;
	logic                   full;
	logic                   do_up;
	logic                   do_down;
	sktab_pkg::status_t     st_code;
	logic [CNT_W-1:0]       count_next;
	sktab_pkg::cell_ctrl_t  ctrl;

	logic                   out_valid_q;
	logic                   found_o_q;
	sktab_pkg::pos_out_t    position_q;
	sktab_pkg::status_t     status_q;
	sktab_pkg::pos_out_t    count_o_q;

	assign in_stall  = state_q != S_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign upd_go    = (state_q == S_UPDATE) && out_free;

	assign key_ord = {key_q[KEY_WIDTH-1] ^ signed_q, key_q[KEY_WIDTH-2:0]};

	assign mid_sum = (CNT_W+1)'(lo_q) + (CNT_W+1)'(hi1_q) - (CNT_W+1)'(1);
	assign mid_w   = mid_sum[CNT_W:1];
	assign mid_idx = mid_w[IDX_W-1:0];

	always_comb begin
		is_ins  = (op_q == sktab_pkg::OP_INSERT) && !found_q;
		is_del  = op_q == sktab_pkg::OP_DELETE;
		full    = count_q == CNT_W'(CAPACITY);
		do_up   = is_ins && !full;
		do_down = is_del && found_q;
		priority if (is_ins && full) begin
			st_code = sktab_pkg::ST_FULL;
		end else if (is_del && !found_q) begin
			st_code = sktab_pkg::ST_ABSENT;
		end else begin
			st_code = sktab_pkg::ST_OK;
		end
		priority if (do_up) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_down) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_comb begin
		ctrl.cmp_load   = state_q == S_CMP;
		ctrl.shift_up   = upd_go && do_up;
		ctrl.shift_down = upd_go && do_down;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_WIDTH-1:0] left_e;
		logic [KEY_WIDTH-1:0] right_e;

		if (g == 0) begin : g_first
			assign left_e = key_q;
		end else begin : g_mid_l
			assign left_e = entry[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_e = entry[g];
		end else begin : g_mid_r
			assign right_e = entry[g+1];
		end

		sktab_cell #(
			.KEY_WIDTH (KEY_WIDTH),
			.CNT_W     (CNT_W),
			.CELL_IDX  (g)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.pos         (pos_q),
			.signed_keys (signed_q),
			.key_ins     (key_q),
			.key_ord     (key_ord),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (entry[g]),
			.lt          (lt_vec[g]),
			.eq          (eq_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			signed_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				signed_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (lo_q >= hi1_q || eq_vec[mid_idx]) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (upd_go) begin
						count_q <= count_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= op;
			key_q <= KEY_WIDTH'(key);
		end
		if (state_q == S_CMP) begin
			lo_q  <= '0;
			hi1_q <= count_q;
		end
		if (state_q == S_SEARCH) begin
			if (lo_q < hi1_q) begin
				priority if (eq_vec[mid_idx]) begin
					found_q <= 1'b1;
					pos_q   <= mid_w;
				end else if (lt_vec[mid_idx]) begin
					hi1_q <= mid_w;
				end else begin
					lo_q <= mid_w + CNT_W'(1);
				end
			end else begin
				found_q <= 1'b0;
				pos_q   <= lo_q;
			end
		end
		if (upd_go) begin
			found_o_q  <= found_q;
			position_q <= sktab_pkg::pos_out_t'(pos_q);
			status_q   <= st_code;
			count_o_q  <= sktab_pkg::pos_out_t'(count_next);
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_o_q;
	assign position  = position_q;
	assign status    = status_q;
	assign count     = count_o_q;

	`SKT_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`SKT_ASSERT_IMP(a_search_bounds, clk, arst_n, state_q == S_SEARCH, lo_q <= hi1_q, "search bounds crossed")
	`SKT_ASSERT_NXT(a_del_count, clk, arst_n, upd_go && do_down, count_q == $past(count_q) - CNT_W'(1), "delete did not drop count")
	`SKT_ASSERT_IMP(a_full_count, clk, arst_n, out_valid_q && status_q == sktab_pkg::ST_FULL, count_q == CNT_W'(CAPACITY), "full reported below capacity")

endmodule

[rtl/sktab_cell.sv]
// one entry of the key table: holds a key, compares it, shifts to neighbors
module sktab_cell #(
	parameter int KEY_WIDTH = sktab_pkg::KEY_WIDTH_DEF,
	parameter int CNT_W     = 9,
	parameter int CELL_IDX  = 0
) (
	input  logic                   clk,
	input  sktab_pkg::cell_ctrl_t  ctrl,
	input  logic [CNT_W-1:0]       pos,
	input  logic                   signed_keys,
	input  logic [KEY_WIDTH-1:0]   key_ins,
	input  logic [KEY_WIDTH-1:0]   key_ord,
	input  logic [KEY_WIDTH-1:0]   left_entry,
	input  logic [KEY_WIDTH-1:0]   right_entry,
	output logic [KEY_WIDTH-1:0]   entry,
	output logic                   lt,
	output logic                   eq
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

	logic [KEY_WIDTH-1:0] entry_q;
	logic [KEY_WIDTH-1:0] entry_ord;
	logic                 lt_q;
	logic                 eq_q;

	assign entry_ord = {entry_q[KEY_WIDTH-1] ^ signed_keys, entry_q[KEY_WIDTH-2:0]};

	always_ff @(posedge clk) begin
		if (ctrl.cmp_load) begin
			lt_q <= key_ord < entry_ord;
			eq_q <= key_ord == entry_ord;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			if (MY_IDX == pos) begin
				entry_q <= key_ins;
			end else if (MY_IDX > pos) begin
				entry_q <= left_entry;
			end
		end else if (ctrl.shift_down) begin
			if (MY_IDX >= pos) begin
				entry_q <= right_entry;
			end
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule
